[hw/rtl/u8u16_pkg.sv]
package u8u16_pkg;

   // Byte classes and code point limits used by the decoder.
   localparam logic [7:0]  LEAD2_BASE   = 8'hc0;
   localparam logic [7:0]  LEAD3_BASE   = 8'he0;
   localparam logic [7:0]  LEAD4_BASE   = 8'hf0;
   localparam logic [7:0]  LEAD_LIMIT   = 8'hf8;
   localparam logic [7:0]  ASCII_LIMIT  = 8'h80;
   localparam logic [20:0] MAX_CODE     = 21'h10ffff;
   localparam logic [20:0] SURR_FIRST   = 21'h00d800;
   localparam logic [20:0] SURR_LAST    = 21'h00dfff;
   localparam logic [20:0] BOM_CODE     = 21'h00feff;
   localparam logic [20:0] PLANE1_BASE  = 21'h010000;
   localparam logic [20:0] MIN_CODE2    = 21'h000080;
   localparam logic [20:0] MIN_CODE3    = 21'h000800;
   localparam logic [15:0] HIGH_SURR    = 16'hd800;
   localparam logic [15:0] LOW_SURR     = 16'hdc00;
   localparam logic [15:0] COUNT_MAX    = 16'hffff;

   // Number of result slots one byte can produce.
   localparam int SLOTS = 3;

   typedef enum logic [1:0] {
      ST_ACTIVE = 2'd0,
      ST_ENDED  = 2'd1,
      ST_ERROR  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_UNIT    = 2'd0,
      KIND_END_OK  = 2'd1,
      KIND_END_ERR = 2'd2
   } kind_type;

   typedef struct packed {
      logic [15:0] unit_value;
      kind_type    result_kind;
      logic [15:0] unit_count;
   } result_type;

   // Everything one input byte produces, in delivery order.
   typedef struct packed {
      result_type [SLOTS-1:0] slot;
      logic [1:0]             num;
   } bundle_type;

endpackage

[hw/rtl/u8u16_req_if.sv]
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

[hw/rtl/u8u16_rsp_if.sv]
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] unit_value;
   logic [1:0]  result_kind;
   logic [15:0] unit_count;
   logic        last_result;

   modport source (output valid, output unit_value, output result_kind,
                   output unit_count, output last_result, input ready);
   modport sink (input valid, input unit_value, input result_kind,
                 input unit_count, input last_result, output ready);
endinterface

[hw/rtl/u8u16_decoder.sv]
module u8u16_decoder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  take,
   input  logic [7:0]            in_byte,
   input  logic                  last_byte,
   output u8u16_pkg::bundle_type bundle
);

   logic [1:0]             remain_ff, remain_in;
   logic [2:0]             seqlen_ff, seqlen_in;
   logic [20:0]            acc_ff, acc_in;
   u8u16_pkg::status_type  status_ff, status_in;
   logic [15:0]            units_ff, units_in;

   logic [1:0]             step_remain;
   logic [2:0]             step_seqlen;
   logic [20:0]            step_acc;
   u8u16_pkg::status_type  step_status;
   logic                   emit_valid;
   logic [20:0]            emit_cp;
   logic [20:0]            shifted;
   logic [20:0]            min_code;
   logic                   skip;
   logic [20:0]            offset;
   logic [1:0]             num_units;
   logic [15:0]            unit0;
   logic [15:0]            unit1;
   logic [16:0]            units_sum;
   logic [15:0]            units_next;
   u8u16_pkg::result_type  end_res;
   u8u16_pkg::result_type  res0;
   u8u16_pkg::result_type  res1;

   // Decode step for one byte against the current sequence state.
   always_comb begin
      step_remain = remain_ff;
      step_seqlen = seqlen_ff;
      step_acc    = acc_ff;
      step_status = status_ff;
      emit_valid  = 1'b0;
      emit_cp     = '0;
      shifted     = {acc_ff[14:0], in_byte[5:0]};
      min_code    = u8u16_pkg::PLANE1_BASE;
      if (seqlen_ff == 3'd2) begin
         min_code = u8u16_pkg::MIN_CODE2;
      end else if (seqlen_ff == 3'd3) begin
         min_code = u8u16_pkg::MIN_CODE3;
      end
      if (status_ff == u8u16_pkg::ST_ACTIVE) begin
         if (remain_ff == 2'd0) begin
            if (in_byte == 8'd0) begin
               step_status = u8u16_pkg::ST_ENDED;
            end else if (in_byte < u8u16_pkg::ASCII_LIMIT) begin
               emit_valid = 1'b1;
               emit_cp    = {13'd0, in_byte};
            end else if (in_byte < u8u16_pkg::LEAD2_BASE) begin
               step_status = u8u16_pkg::ST_ERROR;
            end else if (in_byte < u8u16_pkg::LEAD3_BASE) begin
               step_seqlen = 3'd2;
               step_remain = 2'd1;
               step_acc    = {16'd0, in_byte[4:0]};
            end else if (in_byte < u8u16_pkg::LEAD4_BASE) begin
               step_seqlen = 3'd3;
               step_remain = 2'd2;
               step_acc    = {17'd0, in_byte[3:0]};
            end else if (in_byte < u8u16_pkg::LEAD_LIMIT) begin
               step_seqlen = 3'd4;
               step_remain = 2'd3;
               step_acc    = {18'd0, in_byte[2:0]};
            end else begin
               step_status = u8u16_pkg::ST_ERROR;
            end
         end else if (in_byte[7:6] != 2'b10) begin
            step_status = u8u16_pkg::ST_ERROR;
         end else begin
            step_acc    = shifted;
            step_remain = remain_ff - 2'd1;
            if (remain_ff == 2'd1) begin
               if (shifted < min_code) begin
                  step_status = u8u16_pkg::ST_ERROR;
               end else begin
                  emit_valid = 1'b1;
                  emit_cp    = shifted;
               end
               step_seqlen = 3'd0;
               step_acc    = '0;
            end
         end
         if (step_status == u8u16_pkg::ST_ERROR) begin
            step_remain = 2'd0;
            step_seqlen = 3'd0;
            step_acc    = '0;
         end
      end
   end

   // Code point to UTF-16 units; dropped code points give none.
   always_comb begin
      skip = (emit_cp > u8u16_pkg::MAX_CODE)
          || (emit_cp >= u8u16_pkg::SURR_FIRST && emit_cp <= u8u16_pkg::SURR_LAST)
          || (emit_cp == u8u16_pkg::BOM_CODE);
      offset    = emit_cp - u8u16_pkg::PLANE1_BASE;
      num_units = 2'd0;
      unit0     = emit_cp[15:0];
      unit1     = '0;
      if (emit_valid && !skip) begin
         if (emit_cp < u8u16_pkg::PLANE1_BASE) begin
            num_units = 2'd1;
         end else begin
            num_units = 2'd2;
            unit0     = u8u16_pkg::HIGH_SURR + {6'd0, offset[19:10]};
            unit1     = u8u16_pkg::LOW_SURR + {6'd0, offset[9:0]};
         end
      end
      units_sum  = {1'b0, units_ff} + {15'd0, num_units};
      units_next = units_sum[16] ? u8u16_pkg::COUNT_MAX : units_sum[15:0];
   end

   // Results in delivery order: units first, then the end result.
   always_comb begin
      end_res.unit_value  = '0;
      end_res.unit_count  = units_next;
      end_res.result_kind = u8u16_pkg::KIND_END_OK;
      if (step_status == u8u16_pkg::ST_ERROR
          || (step_status == u8u16_pkg::ST_ACTIVE && step_remain != 2'd0)) begin
         end_res.result_kind = u8u16_pkg::KIND_END_ERR;
      end
      res0.unit_value  = unit0;
      res0.result_kind = u8u16_pkg::KIND_UNIT;
      res0.unit_count  = '0;
      res1.unit_value  = unit1;
      res1.result_kind = u8u16_pkg::KIND_UNIT;
      res1.unit_count  = '0;
      bundle.slot[0] = (num_units != 2'd0) ? res0 : end_res;
      bundle.slot[1] = (num_units == 2'd2) ? res1 : end_res;
      bundle.slot[2] = end_res;
      bundle.num     = num_units + {1'b0, last_byte};
   end

   // State advances on each accepted byte; the last byte restarts the string.
   always_comb begin
      remain_in = remain_ff;
      seqlen_in = seqlen_ff;
      acc_in    = acc_ff;
      status_in = status_ff;
      units_in  = units_ff;
      if (take) begin
         if (last_byte) begin
            remain_in = '0;
            seqlen_in = '0;
            acc_in    = '0;
            status_in = u8u16_pkg::ST_ACTIVE;
            units_in  = '0;
         end else begin
            remain_in = step_remain;
            seqlen_in = step_seqlen;
            acc_in    = step_acc;
            status_in = step_status;
            units_in  = units_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         seqlen_ff <= '0;
         acc_ff    <= '0;
         status_ff <= u8u16_pkg::ST_ACTIVE;
         units_ff  <= '0;
      end else begin
         remain_ff <= remain_in;
         seqlen_ff <= seqlen_in;
         acc_ff    <= acc_in;
         status_ff <= status_in;
         units_ff  <= units_in;
      end
   end

endmodule

[hw/rtl/u8u16_result_queue.sv]
module u8u16_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  u8u16_pkg::bundle_type bundle,
   output logic                  out_valid,
   input  logic                  out_ready,
   output u8u16_pkg::result_type out_result,
   output logic                  out_last
);

   u8u16_pkg::result_type [u8u16_pkg::SLOTS-1:0] slot_ff, slot_in;
   logic [1:0] left_ff, left_in;
   logic [1:0] pos_ff, pos_in;
   logic       drain;
   logic       load;

   // A new byte is taken once the last held result leaves, in the same cycle.
   always_comb begin
      out_valid  = left_ff != 2'd0;
      drain      = out_valid && out_ready;
      in_ready   = (left_ff == 2'd0) || (left_ff == 2'd1 && out_ready);
      load       = in_valid && in_ready;
      out_result = slot_ff[pos_ff];
      out_last   = left_ff == 2'd1;
      slot_in    = slot_ff;
      left_in    = left_ff;
      pos_in     = pos_ff;
      if (load) begin
         slot_in = bundle.slot;
         left_in = bundle.num;
         pos_in  = 2'd0;
      end else if (drain) begin
         left_in = left_ff - 2'd1;
         pos_in  = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         left_ff <= '0;
         pos_ff  <= '0;
      end else begin
         left_ff <= left_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

[hw/rtl/utf8_to_utf16_transcoder.sv]
// Channel   Dir   Fields                                            Transfer
// req_if    in    in_byte[7:0], last_byte                           valid & ready
// rsp_if    out   unit_value[15:0], result_kind[1:0],               valid & ready
//                 unit_count[15:0], last_result
//
// A byte is decoded in the cycle it is accepted; its results appear on rsp_if
// from the next cycle, one per cycle while rsp_if is ready, in order. The result
// register holds up to three results, so a byte giving zero or one result keeps
// one byte per cycle while rsp_if is ready; more results hold off the next byte.
// Reset (synchronous) returns the decoder to the start of a string and empties
// the result register. A stalled rsp_if holds req_if ready low once results queue.
module utf8_to_utf16_transcoder (
   input logic         clock,
   input logic         reset,
   u8u16_req_if.sink   req_if,
   u8u16_rsp_if.source rsp_if
);

   u8u16_pkg::bundle_type bundle;
   u8u16_pkg::result_type result;
   logic                  take;

   assign take = req_if.valid && req_if.ready;

   // Per-byte decode and string state.
   u8u16_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .in_byte   (req_if.in_byte),
      .last_byte (req_if.last_byte),
      .bundle    (bundle)
   );

   // Result register that serializes each transaction's results.
   u8u16_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .bundle     (bundle),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_result (result),
      .out_last   (rsp_if.last_result)
   );

   assign rsp_if.unit_value  = result.unit_value;
   assign rsp_if.result_kind = result.result_kind;
   assign rsp_if.unit_count  = result.unit_count;

endmodule

[dv/utf8_to_utf16_transcoder_tb.sv]
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_tb;

   // One UTF-16 result as it should leave the block.
   typedef struct packed {
      logic [15:0]          unit_value;
      u8u16_pkg::kind_type  result_kind;
      logic [15:0]          unit_count;
      logic                 last_result;
   } utf16_result_type;

   // One row of the directed table. Rows with typed set carry their single
   // expected result; the others are checked against the decoder below.
   typedef struct packed {
      logic [7:0]           in_byte;
      logic                 last_byte;
      logic                 typed;
      logic [15:0]          unit_value;
      u8u16_pkg::kind_type  result_kind;
      logic [15:0]          unit_count;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 24;
   localparam int STEADY_BYTES = 40;
   localparam int RANDOM_BYTES = 230;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_PRINTED = 100;

   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Zero byte right after reset ends an empty string.
      '{8'h00, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_OK,  16'd0},
      // Plain ASCII: a letter, then the highest value.
      '{8'h41, 1'b0, 1'b1, 16'h0041, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h7f, 1'b1, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      // Stray continuation byte, then a byte ignored after the error.
      '{8'h80, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h41, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_ERR, 16'd0},
      // Bad lead byte.
      '{8'hff, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_ERR, 16'd0},
      // Bad continuation inside a two-byte sequence.
      '{8'hc3, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h41, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_ERR, 16'd0},
      // Overlong two-byte form of zero.
      '{8'hc0, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h80, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_ERR, 16'd0},
      // Sequence cut off by the end of the string.
      '{8'he2, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h82, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_ERR, 16'd0},
      // Zero byte at a boundary; the bad byte after it is ignored.
      '{8'h00, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'hff, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_OK,  16'd0},
      // Four-byte character becomes a surrogate pair.
      '{8'hf0, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h9f, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h98, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h80, 1'b1, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      // Encoded surrogate and byte order mark are dropped silently.
      '{8'hed, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'ha0, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'h80, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'hef, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'hbb, 1'b0, 1'b0, 16'h0000, u8u16_pkg::KIND_UNIT,    16'd0},
      '{8'hbf, 1'b1, 1'b1, 16'h0000, u8u16_pkg::KIND_END_OK,  16'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8u16_req_if req_if ();
   u8u16_rsp_if rsp_if ();

   utf8_to_utf16_transcoder dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Decoder state, mirrored from the block.
   logic [1:0]             pend_cont;
   logic [2:0]             seq_len;
   logic [20:0]            code_acc;
   u8u16_pkg::status_type  str_status;
   logic [15:0]            unit_tally;

   utf16_result_type utf16_expected [$];
   utf16_result_type step_results [$];
   logic [7:0]       string_bytes [$];

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  bytes_sent = 0;
   int  strings_sent = 0;
   int  units_predicted = 0;
   int  ok_ends = 0;
   int  error_ends = 0;
   bit  steady_flow = 1'b0;
   bit  rsp_hold = 1'b0;

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Reset is held at the start and released on a falling edge.
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      // Beyond the print limit, mismatches are still counted.
      if (mismatch_count <= MAX_PRINTED)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
   endtask

   task automatic clear_decoder();
      pend_cont = '0;
      seq_len = '0;
      code_acc = '0;
      str_status = u8u16_pkg::ST_ACTIVE;
      unit_tally = '0;
   endtask

   task automatic add_unit(input logic [15:0] value);
      step_results.push_back('{value, u8u16_pkg::KIND_UNIT, 16'd0, 1'b0});
      if (unit_tally != 16'hffff)
         unit_tally++;
   endtask

   // Emits one code point as UTF-16, dropping the values that are skipped.
   task automatic emit_code_point(input logic [20:0] cp);
      logic [20:0] offset;
      if (cp > 21'h10ffff || (cp >= 21'h00d800 && cp <= 21'h00dfff) || cp == 21'h00feff)
         return;
      if (cp < 21'h010000) begin
         add_unit(cp[15:0]);
      end else begin
         offset = cp - 21'h010000;
         add_unit(16'hd800 + {6'd0, offset[19:10]});
         add_unit(16'hdc00 + {6'd0, offset[9:0]});
      end
   endtask

   // Decodes one accepted byte; the results land in step_results.
   task automatic decode_byte(input logic [7:0] b, input logic lst);
      logic [20:0]          floor_cp;
      u8u16_pkg::kind_type  end_kind;
      step_results.delete();
      if (str_status == u8u16_pkg::ST_ACTIVE) begin
         if (pend_cont == 2'd0) begin
            if (b == 8'h00) begin
               str_status = u8u16_pkg::ST_ENDED;
            end else if (b < 8'h80) begin
               emit_code_point({13'd0, b});
            end else if (b < 8'hc0) begin
               str_status = u8u16_pkg::ST_ERROR;
            end else if (b < 8'he0) begin
               seq_len = 3'd2;
               pend_cont = 2'd1;
               code_acc = {16'd0, b[4:0]};
            end else if (b < 8'hf0) begin
               seq_len = 3'd3;
               pend_cont = 2'd2;
               code_acc = {17'd0, b[3:0]};
            end else if (b < 8'hf8) begin
               seq_len = 3'd4;
               pend_cont = 2'd3;
               code_acc = {18'd0, b[2:0]};
            end else begin
               str_status = u8u16_pkg::ST_ERROR;
            end
         end else if (b[7:6] != 2'b10) begin
            str_status = u8u16_pkg::ST_ERROR;
         end else begin
            code_acc = {code_acc[14:0], b[5:0]};
            pend_cont = pend_cont - 2'd1;
            if (pend_cont == 2'd0) begin
               floor_cp = (seq_len == 3'd2) ? 21'h000080 :
                          (seq_len == 3'd3) ? 21'h000800 : 21'h010000;
               if (code_acc < floor_cp)
                  str_status = u8u16_pkg::ST_ERROR;
               else
                  emit_code_point(code_acc);
               seq_len = '0;
               code_acc = '0;
            end
         end
         if (str_status == u8u16_pkg::ST_ERROR) begin
            pend_cont = '0;
            seq_len = '0;
            code_acc = '0;
         end
      end

      // The final byte reports the string and starts a fresh one.
      if (lst) begin
         end_kind = (str_status == u8u16_pkg::ST_ERROR
                     || (str_status == u8u16_pkg::ST_ACTIVE && pend_cont != 2'd0))
                    ? u8u16_pkg::KIND_END_ERR : u8u16_pkg::KIND_END_OK;
         step_results.push_back('{16'h0000, end_kind, unit_tally, 1'b0});
         clear_decoder();
      end
      if (step_results.size() > 0)
         step_results[step_results.size() - 1].last_result = 1'b1;
   endtask

   task automatic queue_expected();
      foreach (step_results[i]) begin
         utf16_expected.push_back(step_results[i]);
         case (step_results[i].result_kind)
            u8u16_pkg::KIND_UNIT:    units_predicted++;
            u8u16_pkg::KIND_END_OK:  ok_ends++;
            u8u16_pkg::KIND_END_ERR: error_ends++;
            default: ;
         endcase
      end
   endtask

   // Offers one byte from a falling edge and returns at the accepting edge.
   task automatic send_byte(input logic [7:0] b, input logic lst);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 19) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.in_byte <= b;
      req_if.last_byte <= lst;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      if (lst)
         strings_sent++;
   endtask

   task automatic send_and_predict(input logic [7:0] b, input logic lst);
      send_byte(b, lst);
      decode_byte(b, lst);
      queue_expected();
   endtask

   // Picks the low end, the high end or a value in between.
   function automatic logic [20:0] pick_code(input int lo, input int hi);
      case ($urandom_range(9))
         0: return 21'(lo);
         1: return 21'(hi);
         default: return 21'($urandom_range(hi, lo));
      endcase
   endfunction

   // Appends cp encoded in len bytes, overlong forms included.
   task automatic push_utf8(input logic [20:0] cp, input int len);
      case (len)
         1: string_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            string_bytes.push_back({3'b110, cp[10:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            string_bytes.push_back({4'b1110, cp[15:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            string_bytes.push_back({5'b11110, cp[20:18]});
            string_bytes.push_back({2'b10, cp[17:12]});
            string_bytes.push_back({2'b10, cp[11:6]});
            string_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endtask

   // Mostly well-formed text with random content, with some malformed
   // characters, noise bytes and strings that stop inside a sequence.
   task automatic build_random_string();
      int n_chars;
      int roll;
      int len;
      string_bytes.delete();
      n_chars = $urandom_range(6, 1);
      repeat (n_chars) begin
         roll = $urandom_range(99);
         if (roll < 2) begin
            string_bytes.push_back(8'h00);
         end else if (roll < 30) begin
            push_utf8(pick_code(1, 'h7f), 1);
         end else if (roll < 45) begin
            push_utf8(pick_code('h80, 'h7ff), 2);
         end else if (roll < 60) begin
            push_utf8(pick_code('h800, 'hffff), 3);
         end else if (roll < 74) begin
            push_utf8(pick_code('h10000, 'h10ffff), 4);
         end else if (roll < 86) begin
            case ($urandom_range(4))
               0: push_utf8(pick_code('hd800, 'hdfff), 3);
               1: push_utf8(21'h00feff, 3);
               2: push_utf8(pick_code('h110000, 'h1fffff), 4);
               3: begin
                  len = $urandom_range(4, 2);
                  push_utf8(pick_code(0, (len == 2) ? 'h7f : (len == 3) ? 'h7ff : 'hffff),
                            len);
               end
               default: string_bytes.push_back(8'($urandom_range(8'hff, 8'h80)));
            endcase
         end else begin
            string_bytes.push_back(8'($urandom_range(255)));
         end
      end
      // About one string in ten ends on a lead byte, maybe with one continuation byte.
      if ($urandom_range(9) == 0) begin
         string_bytes.push_back(8'($urandom_range(8'hf7, 8'hc0)));
         if ($urandom_range(1))
            string_bytes.push_back(8'($urandom_range(8'hbf, 8'h80)));
      end
   endtask

   task automatic send_random_string();
      build_random_string();
      foreach (string_bytes[i])
         send_and_predict(string_bytes[i], i == string_bytes.size() - 1);
   endtask

   // Stimulus: directed table, random strings, one steady ASCII string, more random.
   initial begin
      int random_start;
      req_if.valid <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.last_byte <= 1'b0;
      clear_decoder();
      wait (reset == 1'b0);

      foreach (DIRECTED_ROWS[i]) begin
         send_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].last_byte);
         decode_byte(DIRECTED_ROWS[i].in_byte, DIRECTED_ROWS[i].last_byte);
         if (DIRECTED_ROWS[i].typed) begin
            step_results.delete();
            step_results.push_back('{DIRECTED_ROWS[i].unit_value,
                                     DIRECTED_ROWS[i].result_kind,
                                     DIRECTED_ROWS[i].unit_count, 1'b1});
         end
         queue_expected();
      end

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES)
         send_random_string();

      // An ASCII string sent back to back, with no idling on either side.
      steady_flow = 1'b1;
      for (int i = 0; i < STEADY_BYTES; i++)
         send_and_predict(8'($urandom_range(8'h7f, 8'h01)), i == STEADY_BYTES - 1);
      steady_flow = 1'b0;

      repeat (8)
         send_random_string();

      @(negedge clock);
      req_if.valid <= 1'b0;

      // Drain, then give stray results a chance to show up.
      while (utf16_expected.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d strings in %0d bytes, with directed error and skip cases.",
               strings_sent, bytes_sent);
      $display("Checked %0d results: %0d code units, %0d clean ends, %0d error ends.",
               results_checked, units_predicted, ok_ends, error_ends);
      if (mismatch_count == 0)
         $display("utf8_to_utf16_transcoder test passed");
      else
         $display("utf8_to_utf16_transcoder test failed");
      $finish;
   end

   // Receiver readiness, changed on falling edges.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= rsp_hold ? 1'b0 : (steady_flow || $urandom_range(99) >= 19);
      end
   end

   // Once, early in the random strings, the receiver holds off long enough
   // to fill the result register and back-pressure the input.
   initial begin
      wait (results_checked >= 60);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      rsp_hold = 1'b0;
   end

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      utf16_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_checked++;
         if (utf16_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected result unit=%h kind=%0d count=%0d",
                                      rsp_if.unit_value, rsp_if.result_kind,
                                      rsp_if.unit_count));
         end else begin
            want = utf16_expected.pop_front();
            if (rsp_if.unit_value !== want.unit_value)
               report_mismatch($sformatf("unit_value %h, expected %h",
                                         rsp_if.unit_value, want.unit_value));
            if (rsp_if.result_kind !== want.result_kind)
               report_mismatch($sformatf("result_kind %0d, expected %0d",
                                         rsp_if.result_kind, want.result_kind));
            if (rsp_if.unit_count !== want.unit_count)
               report_mismatch($sformatf("unit_count %0d, expected %0d",
                                         rsp_if.unit_count, want.unit_count));
            if (rsp_if.last_result !== want.last_result)
               report_mismatch($sformatf("last_result %b, expected %b",
                                         rsp_if.last_result, want.last_result));
         end
      end
   end

   // Watchdog for a hung run.
   initial begin
      #10_000_000;
      $display("Timed out with %0d results outstanding.", utf16_expected.size());
      $display("utf8_to_utf16_transcoder test failed");
      $finish;
   end

endmodule
